>>> sv/uartsr_pkg.sv
// Package: payload beats, configuration, opcodes and register indexes.
`timescale 1ns / 1ps

package uartsr_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_PEEK  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    REG_BIT_PERIOD   = 2'd0,
    REG_LONG_MODE    = 2'd1,
    REG_BREAK_ENABLE = 2'd2
  } reg_index_e;

  localparam int unsigned BitPeriodW = 15;
  localparam int unsigned TimerW     = 16;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIndexW  = 2;

  localparam logic [3:0] RxSamplesLong  = 4'd11;
  localparam logic [3:0] RxSamplesShort = 4'd10;

  typedef struct packed {
    opcode_e     opcode;
    logic [15:0] write_value;
    logic        rxd_level;
    logic        rbf_pending;
  } in_t;

  typedef struct packed {
    logic        txd;
    logic [15:0] read_value;
    logic        tbe_request;
    logic        rbf_request;
  } out_t;

  typedef struct packed {
    logic [BitPeriodW-1:0] bit_period;
    logic                  long_mode;
    logic                  break_enable;
  } cfg_t;

endpackage

>>> sv/uart_tx_rx_with_status_register_top.sv
// Top level: configuration registers, UART core and registered output with skid stage.
`timescale 1ns / 1ps

// One beat is accepted every clock cycle while in_stall_o is low; its result is
// registered into the output register, or the skid stage if the output stalls.
// Each beat is a tick, a transmit write or a status read; bit timing counts tick
// beats only, bit_period+1 ticks per bit. The output register is backed by a
// one-entry skid stage, so in_stall_o rises only after the result side has
// stalled with a result already waiting. Configuration writes are always taken
// (cfg_ready_o is tied high); writes to an index beyond the register list are ignored.

module uart_tx_rx_with_status_register_top
  import uartsr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  cfg_t cfg_q;
  out_t result;
  out_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic accept;
  logic out_free;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i & ~skid_valid_q;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BIT_PERIOD:   cfg_q.bit_period   <= cfg_data_i[BitPeriodW-1:0];
        REG_LONG_MODE:    cfg_q.long_mode    <= cfg_data_i[0];
        REG_BREAK_ENABLE: cfg_q.break_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  uartsr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .item_i   (in_data_i),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q | accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= result;
      end
    end else if (accept) begin
      skid_q <= result;
    end
  end

endmodule

>>> sv/uartsr_core.sv
// UART state and combinational item processing: transmitter, receiver, status.
`timescale 1ns / 1ps

module uartsr_core
  import uartsr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic accept_i,
  input  in_t  item_i,
  output out_t result_o
);

  logic [15:0]       tx_holding_q, tx_holding_d;
  logic [16:0]       tx_shift_q, tx_shift_d;
  logic [TimerW-1:0] tx_timer_q, tx_timer_d;
  logic              tx_line_q, tx_line_d;
  logic [10:0]       rx_shift_q, rx_shift_d;
  logic [3:0]        rx_count_q, rx_count_d;
  logic [TimerW-1:0] rx_timer_q, rx_timer_d;
  logic              rx_active_q, rx_active_d;
  logic [9:0]        rx_word_q, rx_word_d;
  logic              overrun_q, overrun_d;
  logic              last_rxd_q, last_rxd_d;

  logic [TimerW-1:0] bit_ticks;
  logic [TimerW-1:0] tx_timer_dec;
  logic [16:0]       tx_shift_next;
  logic [10:0]       rx_shift_next;
  logic [3:0]        rx_count_next;
  logic [3:0]        rx_samples;
  logic [9:0]        rev_long, rev_short;
  logic              show_overrun;
  logic [15:0]       status;

  assign bit_ticks     = TimerW'({1'b0, cfg_i.bit_period}) + TimerW'(1);
  assign tx_timer_dec  = tx_timer_q - TimerW'(1);
  assign tx_shift_next = tx_shift_q >> 1;
  assign rx_shift_next = {rx_shift_q[9:0], item_i.rxd_level};
  assign rx_count_next = rx_count_q + 4'd1;
  assign rx_samples    = cfg_i.long_mode ? RxSamplesLong : RxSamplesShort;

  always_comb begin
    for (int k = 0; k < 10; k++) begin
      rev_long[k] = rx_shift_next[9-k];
    end
    for (int k = 0; k < 9; k++) begin
      rev_short[k] = rx_shift_next[8-k];
    end
    rev_short[9] = 1'b0;
  end

  always_comb begin
    tx_holding_d = tx_holding_q;
    tx_shift_d   = tx_shift_q;
    tx_timer_d   = tx_timer_q;
    tx_line_d    = tx_line_q;
    rx_shift_d   = rx_shift_q;
    rx_count_d   = rx_count_q;
    rx_timer_d   = rx_timer_q;
    rx_active_d  = rx_active_q;
    rx_word_d    = rx_word_q;
    overrun_d    = overrun_q;
    show_overrun = 1'b0;
    result_o     = '0;

    unique case (item_i.opcode)
      OP_TICK: begin
        if (tx_timer_q != '0) begin
          tx_timer_d = tx_timer_dec;
          if (tx_timer_dec == '0) begin
            tx_shift_d = tx_shift_next;
            if (tx_shift_next != '0 || tx_holding_q != '0) begin
              if (tx_shift_next == '0) begin
                tx_shift_d           = {tx_holding_q, 1'b0};
                tx_holding_d         = '0;
                result_o.tbe_request = 1'b1;
                tx_line_d            = 1'b0;
              end else begin
                tx_line_d = tx_shift_next[0];
              end
              tx_timer_d = bit_ticks;
            end
          end
        end
        if (rx_active_q) begin
          if (rx_timer_q > TimerW'(1)) begin
            rx_timer_d = rx_timer_q - TimerW'(1);
          end else if (rx_count_next >= rx_samples) begin
            rx_word_d            = cfg_i.long_mode ? rev_long : rev_short;
            rx_shift_d           = '0;
            rx_count_d           = '0;
            overrun_d            = item_i.rbf_pending;
            result_o.rbf_request = 1'b1;
            rx_active_d          = 1'b0;
            rx_timer_d           = '0;
          end else begin
            rx_shift_d = rx_shift_next;
            rx_count_d = rx_count_next;
            rx_timer_d = bit_ticks;
          end
        end
      end
      OP_WRITE: begin
        tx_holding_d = item_i.write_value;
        if (item_i.write_value != '0 && tx_shift_q == '0) begin
          tx_shift_d           = {item_i.write_value, 1'b0};
          tx_holding_d         = '0;
          result_o.tbe_request = 1'b1;
          tx_line_d            = 1'b0;
          tx_timer_d           = bit_ticks;
        end
      end
      OP_READ: begin
        if (!item_i.rbf_pending) begin
          overrun_d = 1'b0;
        end
        show_overrun = overrun_d;
      end
      OP_PEEK: begin
        show_overrun = item_i.rbf_pending & overrun_q;
      end
      default: ;
    endcase

    // falling edge on rxd arms the receiver, first sample after half a bit
    if (last_rxd_q && !item_i.rxd_level && !rx_active_d) begin
      rx_count_d  = '0;
      rx_active_d = 1'b1;
      rx_timer_d  = bit_ticks >> 1;
    end

    status = {show_overrun, item_i.rbf_pending, (tx_holding_q == '0), (tx_shift_q == '0),
              item_i.rxd_level, 1'b0, rx_word_q};
    if (item_i.opcode == OP_READ || item_i.opcode == OP_PEEK) begin
      result_o.read_value = status;
    end
    result_o.txd = tx_line_d & ~cfg_i.break_enable;
  end

  assign last_rxd_d = item_i.rxd_level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_holding_q <= '0;
      tx_shift_q   <= '0;
      tx_timer_q   <= '0;
      tx_line_q    <= 1'b0;
      rx_shift_q   <= '0;
      rx_count_q   <= '0;
      rx_timer_q   <= '0;
      rx_active_q  <= 1'b0;
      rx_word_q    <= '0;
      overrun_q    <= 1'b0;
      last_rxd_q   <= 1'b1;
    end else if (accept_i) begin
      tx_holding_q <= tx_holding_d;
      tx_shift_q   <= tx_shift_d;
      tx_timer_q   <= tx_timer_d;
      tx_line_q    <= tx_line_d;
      rx_shift_q   <= rx_shift_d;
      rx_count_q   <= rx_count_d;
      rx_timer_q   <= rx_timer_d;
      rx_active_q  <= rx_active_d;
      rx_word_q    <= rx_word_d;
      overrun_q    <= overrun_d;
      last_rxd_q   <= last_rxd_d;
    end
  end

endmodule

>>> sv/uartsr_checker.sv
// Port-level checker for the UART top level, with its bind.
`timescale 1ns / 1ps

module uartsr_checker
  import uartsr_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (!out_valid_o || !out_stall_i) |=> out_valid_o)
    else $error("accepted beat did not reach the output");

  a_req_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.tbe_request || out_data_o.rbf_request)
      |-> out_data_o.read_value == '0)
    else $error("interrupt request with a status word");

endmodule

bind uart_tx_rx_with_status_register_top uartsr_checker u_uartsr_checker (.*);
